// ----- rtl/core/cmfb_pkg.sv -----
// Package with the constants, types and CRC function of the monitoring frame builder.
package cmfb_pkg;

    localparam int unsigned PAYLOAD_WORDS = 13;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned CFG_IDX_W     = 8;
    localparam int unsigned CFG_DATA_W    = 48;

    localparam logic [IDX_W-1:0] IDX_PAYLOAD   = 6'd33;
    localparam logic [IDX_W-1:0] IDX_WORD_END  = 6'd36;
    localparam logic [IDX_W-1:0] IDX_FRAME_END = 6'd44;
    localparam logic [IDX_W-1:0] IDX_COVER_LO  = 6'd4;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] START_MARK = 32'h4996_02D2;
    localparam logic [31:0] END_MARK   = 32'hB669_FD2E;

    localparam logic [31:0] LENGTH_RST = 32'd85;
    localparam logic [7:0]  MSG_RST    = 8'h00;
    localparam logic [47:0] DEST_RST   = 48'h0103_0302_0000;
    localparam logic [47:0] SRC_RST    = 48'h0103_0305_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC    = 8'd3;

    typedef struct packed {
        logic [31:0] length_value;
        logic [7:0]  message_type;
        logic [47:0] destination_address;
        logic [47:0] source_address;
    } t_cfg;

    typedef struct packed {
        logic       update;
        logic       clear;
        logic [7:0] data;
    } t_crc_ctrl;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/cmfb_in_if.sv -----
// Input channel carrying one payload word with its frame header fields.
interface cmfb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sequence_number;
    logic [63:0] timestamp_ms;
    logic [31:0] payload_word;

    modport source (output valid, sequence_number, timestamp_ms, payload_word, input ready);
    modport sink (input valid, sequence_number, timestamp_ms, payload_word, output ready);
endinterface

// ----- rtl/core/cmfb_out_if.sv -----
// Output channel carrying one frame byte with its end flags.
interface cmfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       item_done;
    logic       frame_done;

    modport source (output valid, frame_byte, item_done, frame_done, input ready);
    modport sink (input valid, frame_byte, item_done, frame_done, output ready);
endinterface

// ----- rtl/core/cmfb_cfg_if.sv -----
// Configuration write channel carrying a register index and write data.
interface cmfb_cfg_if;
    import cmfb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cmfb_cfg_regs.sv -----
// Configuration register bank of the monitoring frame builder.
module cmfb_cfg_regs
    import cmfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmfb_cfg_if.sink  i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LENGTH: n_cfg.length_value        = i_cfg.data[31:0];
                CFG_MSG:    n_cfg.message_type        = i_cfg.data[7:0];
                CFG_DEST:   n_cfg.destination_address = i_cfg.data;
                CFG_SRC:    n_cfg.source_address      = i_cfg.data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.length_value        <= LENGTH_RST;
            r_cfg.message_type        <= MSG_RST;
            r_cfg.destination_address <= DEST_RST;
            r_cfg.source_address      <= SRC_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/core/cmfb_crc.sv -----
// Running CRC-32 register, updated by one frame byte per cycle while the byte sequencer advances.
module cmfb_crc
    import cmfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctrl   i_ctrl,
    output logic [31:0] o_crc
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;

    assign o_crc = r_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CRC_ONES;
        end else if (i_ctrl.update) begin
            n_crc = crc_byte(r_crc, i_ctrl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ONES;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

// ----- rtl/core/cmfb_byte_seq.sv -----
// Word register, byte sequencer and output register of the frame builder.
module cmfb_byte_seq
    import cmfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cmfb_in_if.sink     i_in,
    cmfb_out_if.source  o_out,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_crc,
    output t_crc_ctrl   o_crc_ctrl
);

    logic [POS_W-1:0] r_pos;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic [31:0]      r_seq;
    logic [63:0]      r_ts;
    logic [31:0]      r_word;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_item_done;
    logic             r_out_frame_done;

    logic             accept;
    logic             advance;
    logic             end_now;
    logic             in_first;
    logic             in_last;
    logic [POS_W:0]   pos_inc;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] sel;
    logic [359:0]     frame_v;
    logic [7:0]       cur_byte;

    assign pos_inc  = {1'b0, r_pos} + {{POS_W{1'b0}}, 1'b1};
    assign in_first = (r_pos == '0);
    assign in_last  = (pos_inc >= (POS_W+1)'(PAYLOAD_WORDS));

    assign end_idx = r_last ? IDX_FRAME_END : IDX_WORD_END;
    assign advance = r_busy && (!r_out_valid || o_out.ready);
    assign end_now = advance && (r_idx == end_idx);

    assign i_in.ready = !r_busy || end_now;
    assign accept     = i_in.valid && i_in.ready;

    assign frame_v = {START_MARK, i_cfg.length_value, i_cfg.destination_address,
                      i_cfg.source_address, i_cfg.message_type, r_seq, r_ts, r_word,
                      i_crc ^ CRC_ONES, END_MARK};
    assign sel      = IDX_FRAME_END - r_idx;
    assign cur_byte = frame_v[{sel, 3'b000} +: 8];

    assign o_crc_ctrl.update = advance && (r_idx >= IDX_COVER_LO) && (r_idx <= IDX_WORD_END);
    assign o_crc_ctrl.clear  = end_now && r_last;
    assign o_crc_ctrl.data   = cur_byte;

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.item_done  = r_out_item_done;
    assign o_out.frame_done = r_out_frame_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_idx  <= in_first ? '0 : IDX_PAYLOAD;
                r_last <= in_last;
                r_pos  <= in_last ? '0 : pos_inc[POS_W-1:0];
            end else if (end_now) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_idx <= r_idx + 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq  <= i_in.sequence_number;
            r_ts   <= i_in.timestamp_ms;
            r_word <= i_in.payload_word;
        end
        if (advance) begin
            r_out_byte       <= cur_byte;
            r_out_item_done  <= (r_idx == end_idx);
            r_out_frame_done <= r_last && (r_idx == IDX_FRAME_END);
        end
    end

endmodule

// ----- rtl/core/crc32_monitoring_frame_builder.sv -----
// Top level of the monitoring frame builder with CRC-32 trailer.
// Each accepted payload word produces frame bytes on the output channel, one byte per
// cycle while the output is ready, big-endian: a middle word gives 4 bytes, the first
// word of a frame 37 (start marker, length, addresses, message type, sequence number,
// timestamp and the word), and the last word 8 more for the CRC and the end marker.
// The byte rate is set by the single byte-wide output register; the next word is taken
// in the cycle its predecessor hands over its last byte, so a steady stream of middle
// words runs without gaps. Configuration writes take effect for bytes built after them.
module crc32_monitoring_frame_builder
    import cmfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmfb_in_if.sink    i_in,
    cmfb_out_if.source o_out,
    cmfb_cfg_if.sink   i_cfg
);

    t_cfg        cfg;
    t_crc_ctrl   crc_ctrl;
    logic [31:0] crc;

    cmfb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cmfb_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc)
    );

    cmfb_byte_seq u_byte_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (cfg),
        .i_crc      (crc),
        .o_crc_ctrl (crc_ctrl)
    );

endmodule
